// ===== design/ske_pkg.sv =====
// Shared definitions for the scalar Kalman estimator: field widths, reset values,
// configuration register indexes and the control struct for the serial units.
// No dependencies.
package ske_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int GAIN_BITS     = 16;
  localparam int DATA_W        = 16;
  localparam int STATE_W       = 32;
  localparam int CFG_IDX_W     = 2;

  localparam logic        [DATA_W-1:0] MEAS_VAR_RESET = 16'd25;
  localparam logic signed [DATA_W-1:0] INIT_EST_RESET = 16'sd980;
  localparam logic        [DATA_W-1:0] INIT_VAR_RESET = 16'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MEAS_VAR = 2'd0,
    REG_INIT_EST = 2'd1,
    REG_INIT_VAR = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic load;
    logic step;
  } ske_step_t;

endpackage

// ===== design/ske_div.sv =====
// Restoring divider for the Kalman gain, one quotient bit per step:
// quotient = floor((variance << GAIN_BITS) / (variance + (meas_variance << FRAC_BITS))).
// Depends on ske_pkg.
module ske_div #(
  parameter int FRAC_BITS = ske_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  ske_pkg::ske_step_t             ctrl,
  input  logic [ske_pkg::STATE_W-1:0]    variance,
  input  logic [ske_pkg::DATA_W-1:0]     meas_variance,
  output logic [ske_pkg::GAIN_BITS-1:0]  quotient
);
  import ske_pkg::*;

  localparam int MV_W  = DATA_W + FRAC_BITS;
  localparam int DEN_W = ((MV_W > STATE_W) ? MV_W : STATE_W) + 1;

  logic [DEN_W-1:0] den;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] rem_next;
  logic [DEN_W:0]   trial;
  logic [DEN_W+1:0] sub;
  logic             bit_q;

  // The remainder starts as the variance, which is below the denominator
  // whenever the measurement variance is non-zero, so the quotient fits.
  always_comb begin
    trial    = {rem, 1'b0};
    sub      = {1'b0, trial} - {2'b00, den};
    bit_q    = !sub[DEN_W+1];
    rem_next = bit_q ? sub[DEN_W-1:0] : trial[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      den <= DEN_W'(variance) + (DEN_W'(meas_variance) << FRAC_BITS);
      rem <= DEN_W'(variance);
    end else if (ctrl.step) begin
      rem      <= rem_next;
      quotient <= {quotient[GAIN_BITS-2:0], bit_q};
    end
  end

endmodule

// ===== design/ske_mul.sv =====
// Shift-and-add multiplier, one multiplier bit per step, least significant first.
// The accumulator shifts right each step, so it ends as floor(a * b / 2**GAIN_BITS).
// Depends on ske_pkg.
module ske_mul #(
  parameter int A_W = ske_pkg::STATE_W
) (
  input  logic                           clk,
  input  ske_pkg::ske_step_t             ctrl,
  input  logic [A_W-1:0]                 multiplicand,
  input  logic [ske_pkg::GAIN_BITS-1:0]  multiplier,
  output logic [A_W-1:0]                 product
);
  import ske_pkg::*;

  logic [A_W-1:0]       a;
  logic [GAIN_BITS-1:0] b;
  logic [A_W:0]         sum;

  always_comb begin
    sum = {1'b0, product} + (b[0] ? {1'b0, a} : '0);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      a       <= multiplicand;
      b       <= multiplier;
      product <= '0;
    end else if (ctrl.step) begin
      product <= sum[A_W:1];
      b       <= b >> 1;
    end
  end

endmodule

// ===== design/scalar_kalman_estimator.sv =====
// Scalar Kalman estimator for one signed 16-bit accelerometer axis.
// Depends on ske_pkg, ske_div and ske_mul.
//
// Input channel (in_valid/in_ready, sample): one request per raw reading.
// Output channel (out_valid/out_ready): the updated estimate (signed Q16.16)
// and error variance (unsigned Q16.16) for each request, in order.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready: index 0 sets the measurement variance, index 1 reloads the estimate
// from an integer, index 2 reloads the variance; other indexes are ignored.
// Write it only while no request is in flight.
//
// Each request passes in order through the bit-serial gain divider, a step
// that fixes the gain, the two shift-add multipliers, then a step that forms
// the correction and a step that updates the state.
// A new request is taken only once the result is registered and the block
// is idle again, not while one is in flight. The result register holds its
// request while out_ready is low; the block waits in its last step until the
// register is free. Synchronous reset loads measurement variance 25, estimate
// 980 and variance 255, and empties the result register.
module scalar_kalman_estimator #(
  parameter int FRAC_BITS = ske_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [ske_pkg::DATA_W-1:0]   sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ske_pkg::STATE_W-1:0]  estimate_q16,
  output logic        [ske_pkg::STATE_W-1:0]  variance_q16,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic        [ske_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [ske_pkg::DATA_W-1:0]   cfg_data
);
  import ske_pkg::*;

  localparam int SMP_W  = DATA_W + FRAC_BITS;
  localparam int SD_W   = ((SMP_W > STATE_W) ? SMP_W : STATE_W) + 1;
  localparam int VW     = ((SMP_W > STATE_W) ? SMP_W : STATE_W) + 1;
  localparam int CNT_W  = $clog2(GAIN_BITS);
  localparam int LAT    = 2 * GAIN_BITS + 3;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GAIN_BITS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_GAIN,
    ST_MUL,
    ST_CORR,
    ST_DONE
  } state_t;

  state_t                    state;
  logic [CNT_W-1:0]          cnt;
  logic [DATA_W-1:0]         meas_variance;
  logic signed [STATE_W-1:0] estimate;
  logic [STATE_W-1:0]        variance;
  logic signed [SD_W-1:0]    diff;
  logic [GAIN_BITS-1:0]      gain;
  logic signed [SD_W-1:0]    corr;

  logic                      in_acc;
  logic                      finish;
  ske_step_t                 div_ctrl;
  ske_step_t                 mul_ctrl;
  logic [GAIN_BITS-1:0]      quotient;
  logic [GAIN_BITS-1:0]      gain_next;
  logic [GAIN_BITS-1:0]      var_mult;
  logic signed [SD_W-1:0]    diff_next;
  logic [SD_W-1:0]           mag_in;
  logic [SD_W-1:0]           est_prod;
  logic [STATE_W-1:0]        var_prod;
  logic signed [SD_W-1:0]    corr_next;
  logic signed [SD_W:0]      sum;
  logic                      est_ovf;
  logic signed [STATE_W-1:0] est_new;
  logic [STATE_W-1:0]        var_new;
  logic signed [DATA_W-1:0]  est_src;
  logic signed [SD_W-1:0]    est_wide;
  logic signed [STATE_W-1:0] est_load;
  logic [DATA_W-1:0]         var_src;
  logic [VW-1:0]             var_wide;
  logic [STATE_W-1:0]        var_load;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign finish    = (state == ST_DONE) && (!out_valid || out_ready);

  assign div_ctrl.load = in_acc;
  assign div_ctrl.step = (state == ST_DIV);
  assign mul_ctrl.load = (state == ST_GAIN);
  assign mul_ctrl.step = (state == ST_MUL);

  always_comb begin
    // With no measurement variance the gain would be unity, which does not
    // fit in Q0.16, so it saturates; a zero denominator gives no gain at all.
    if (meas_variance == '0) begin
      gain_next = (variance != '0) ? '1 : '0;
    end else begin
      gain_next = quotient;
    end
    var_mult  = ~gain_next + 1'b1;
    diff_next = (SD_W'(sample) <<< FRAC_BITS) - SD_W'(estimate);
    mag_in    = diff[SD_W-1] ? SD_W'(-diff) : SD_W'(diff);
    // The magnitude is scaled, so the correction truncates towards zero.
    corr_next = diff[SD_W-1] ? -$signed(est_prod) : $signed(est_prod);
    sum       = (SD_W+1)'(estimate) + (SD_W+1)'(corr);
    est_ovf   = (sum[SD_W:STATE_W-1] != '0) && (sum[SD_W:STATE_W-1] != '1);
    if (est_ovf) begin
      est_new = sum[SD_W] ? {1'b1, {(STATE_W-1){1'b0}}} : {1'b0, {(STATE_W-1){1'b1}}};
    end else begin
      est_new = sum[STATE_W-1:0];
    end
    // A zero gain keeps the whole variance; the multiplier only covers 1 - K below unity.
    var_new = (gain == '0) ? variance : var_prod;
  end

  // Reset and register writes of the estimate and variance share one reload path.
  always_comb begin
    est_src  = rst ? INIT_EST_RESET : $signed(cfg_data);
    est_wide = SD_W'(est_src) <<< FRAC_BITS;
    if ((est_wide[SD_W-1:STATE_W-1] != '0) && (est_wide[SD_W-1:STATE_W-1] != '1)) begin
      est_load = est_wide[SD_W-1] ? {1'b1, {(STATE_W-1){1'b0}}}
                                  : {1'b0, {(STATE_W-1){1'b1}}};
    end else begin
      est_load = est_wide[STATE_W-1:0];
    end
    var_src  = rst ? INIT_VAR_RESET : cfg_data;
    var_wide = VW'(var_src) << FRAC_BITS;
    var_load = (|var_wide[VW-1:STATE_W]) ? '1 : var_wide[STATE_W-1:0];
  end

  ske_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk          (clk),
    .ctrl         (div_ctrl),
    .variance     (variance),
    .meas_variance(meas_variance),
    .quotient     (quotient)
  );

  ske_mul #(
    .A_W(SD_W)
  ) u_mul_est (
    .clk         (clk),
    .ctrl        (mul_ctrl),
    .multiplicand(mag_in),
    .multiplier  (gain_next),
    .product     (est_prod)
  );

  ske_mul #(
    .A_W(STATE_W)
  ) u_mul_var (
    .clk         (clk),
    .ctrl        (mul_ctrl),
    .multiplicand(variance),
    .multiplier  (var_mult),
    .product     (var_prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cnt           <= '0;
      out_valid     <= 1'b0;
      meas_variance <= MEAS_VAR_RESET;
      estimate      <= est_load;
      variance      <= var_load;
    end else begin
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_MEAS_VAR: meas_variance <= cfg_data;
          REG_INIT_EST: estimate      <= est_load;
          REG_INIT_VAR: variance      <= var_load;
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            diff  <= diff_next;
            cnt   <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_LAST) begin
            state <= ST_GAIN;
          end
        end
        ST_GAIN: begin
          gain  <= gain_next;
          cnt   <= '0;
          state <= ST_MUL;
        end
        ST_MUL: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_LAST) begin
            state <= ST_CORR;
          end
        end
        ST_CORR: begin
          corr  <= corr_next;
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (finish) begin
            estimate     <= est_new;
            variance     <= var_new;
            estimate_q16 <= est_new;
            variance_q16 <= var_new;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_var_no_growth: assert property (@(posedge clk) disable iff (rst)
    finish |=> (variance <= $past(variance)))
    else $error("error variance grew through an update");

  a_zero_gain_hold: assert property (@(posedge clk) disable iff (rst)
    (finish && (gain == '0)) |=> (estimate == $past(estimate)))
    else $error("estimate moved although the gain was zero");

  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    in_acc |-> ##LAT (state == ST_DONE))
    else $error("request did not reach the update step on time");

  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((estimate_q16 == estimate) && (variance_q16 == variance)))
    else $error("pending result differs from the stored state");

endmodule
